// ===== rtl/gae_pkg.sv =====
package gae_pkg;

  localparam int MAX_POP  = 128;
  localparam int POP_W    = 7;
  localparam int GENES    = 20;
  localparam int ALLELE_W = 2;
  localparam int GENOME_W = GENES * ALLELE_W;
  localparam int SCORE_W  = 5;
  localparam int SUM_W    = 12;
  localparam int DRAW_W   = 16;
  localparam int CUT_W    = 5;
  localparam int SIZE_W   = 8;
  localparam int APB_AW   = 4;
  localparam int APB_DW   = 64;

  // Register byte addresses on the configuration port.
  localparam logic [APB_AW-1:0] ADDR_MODEL = 4'h0;
  localparam logic [APB_AW-1:0] ADDR_SIZE  = 4'h8;

  typedef enum logic [1:0] {
    ACT_LOAD   = 2'd0,
    ACT_EVAL   = 2'd1,
    ACT_BREED  = 2'd2,
    ACT_COMMIT = 2'd3
  } action_t;

  typedef enum logic [1:0] {
    DIV_P1  = 2'd0,
    DIV_P2  = 2'd1
  } div_sel_t;

  typedef enum logic [4:0] {
    S_IDLE, S_LOAD, S_EV_RD, S_EV_SC,
    S_D1_GO, S_D1_WT, S_D2_GO, S_D2_WT,
    S_WK_RD, S_WK_CHK, S_RD_A, S_RD_B, S_CHILD,
    S_CM_RD, S_CM_WR, S_DONE
  } state_t;

  typedef struct packed {
    logic [1:0]          action;
    logic [POP_W-1:0]    organism_index;
    logic [GENOME_W-1:0] genome;
    logic [DRAW_W-1:0]   select_draw_one;
    logic [DRAW_W-1:0]   select_draw_two;
    logic [DRAW_W-1:0]   crossover_draw;
    logic [GENES-1:0]    mutation_mask;
    logic [GENOME_W-1:0] mutant_genome;
  } in_word_t;

  typedef struct packed {
    logic             perfect_found;
    logic [POP_W-1:0] perfect_index;
    logic [SUM_W-1:0] fitness_total;
    logic [POP_W-1:0] parent_one;
    logic [POP_W-1:0] parent_two;
  } out_word_t;

  typedef struct packed {
    logic     latch;
    logic     load_wr;
    logic     ev_sc;
    logic     div_go;
    logic     div_take;
    div_sel_t div_sel;
    logic     wk_chk;
    logic     rd_a;
    logic     rd_b;
    logic     child_wr;
    logic     cm_wr;
  } gae_cmd_t;

  typedef struct packed {
    logic ev_stop;
    logic div_done;
    logic wk_stop;
    logic k_last;
  } gae_stat_t;

endpackage

// ===== rtl/gae_div.sv =====
module gae_div
  import gae_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  input  logic [DRAW_W-1:0] dividend,
  input  logic [SUM_W-1:0]  divisor,
  output logic              done,
  output logic [SUM_W-1:0]  remainder
);

  logic              busy;
  logic [3:0]        cnt;
  logic [DRAW_W-1:0] shreg;
  logic [SUM_W:0]    rem;
  logic [SUM_W:0]    trial;

  // One restoring step per cycle, most significant dividend bit first.
  always_comb begin
    trial = {rem[SUM_W-1:0], shreg[DRAW_W-1]};
    if (trial >= {1'b0, divisor}) begin
      trial = trial - {1'b0, divisor};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + 4'd1;
        if (cnt == 4'd15) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem   <= '0;
      shreg <= dividend;
    end else if (busy) begin
      rem   <= trial;
      shreg <= {shreg[DRAW_W-2:0], 1'b0};
    end
  end

  assign remainder = rem[SUM_W-1:0];

endmodule

// ===== rtl/gae_ctrl.sv =====
module gae_ctrl
  import gae_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  logic      in_valid,
  input  action_t   action,
  input  logic      out_free,
  input  gae_stat_t stat,
  output logic      in_stall,
  output logic      out_load,
  output gae_cmd_t  cmd
);

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Next state.
  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (in_valid) begin
          unique case (action)
            ACT_LOAD:   state_next = S_LOAD;
            ACT_EVAL:   state_next = S_EV_RD;
            ACT_BREED:  state_next = S_D1_GO;
            ACT_COMMIT: state_next = S_CM_RD;
            default:    state_next = S_IDLE;
          endcase
        end
      end
      S_LOAD:   state_next = S_DONE;
      S_EV_RD:  state_next = S_EV_SC;
      S_EV_SC:  state_next = stat.ev_stop ? S_DONE : S_EV_RD;
      S_D1_GO:  state_next = S_D1_WT;
      S_D1_WT:  state_next = stat.div_done ? S_D2_GO : S_D1_WT;
      S_D2_GO:  state_next = S_D2_WT;
      S_D2_WT:  state_next = stat.div_done ? S_WK_RD : S_D2_WT;
      S_WK_RD:  state_next = S_WK_CHK;
      S_WK_CHK: state_next = stat.wk_stop ? S_RD_A : S_WK_RD;
      S_RD_A:   state_next = S_RD_B;
      S_RD_B:   state_next = S_CHILD;
      S_CHILD:  state_next = S_DONE;
      S_CM_RD:  state_next = S_CM_WR;
      S_CM_WR:  state_next = stat.k_last ? S_DONE : S_CM_RD;
      S_DONE:   state_next = out_free ? S_IDLE : S_DONE;
      default:  state_next = S_IDLE;
    endcase
  end

  // Commands to the datapath.
  always_comb begin
    cmd          = '0;
    cmd.div_sel  = DIV_P1;
    in_stall     = (state != S_IDLE);
    out_load     = (state == S_DONE) && out_free;
    cmd.latch    = (state == S_IDLE) && in_valid;
    cmd.load_wr  = (state == S_LOAD);
    cmd.ev_sc    = (state == S_EV_SC);
    cmd.div_go   = (state == S_D1_GO) || (state == S_D2_GO);
    cmd.div_take = (state == S_D1_WT) || (state == S_D2_WT);
    if ((state == S_D2_GO) || (state == S_D2_WT)) begin
      cmd.div_sel = DIV_P2;
    end
    cmd.wk_chk   = (state == S_WK_CHK);
    cmd.rd_a     = (state == S_RD_A);
    cmd.rd_b     = (state == S_RD_B);
    cmd.child_wr = (state == S_CHILD);
    cmd.cm_wr    = (state == S_CM_WR);
  end

endmodule

// ===== rtl/gae_dp.sv =====
module gae_dp
  import gae_pkg::*;
(
  input  logic                clk,
  input  logic                rst,
  input  gae_cmd_t            cmd,
  input  in_word_t            in_word,
  input  logic [GENOME_W-1:0] model_genome,
  input  logic [SIZE_W-1:0]   population_size,
  output gae_stat_t           stat,
  output out_word_t           result
);

  logic [GENOME_W-1:0] cur_mem [MAX_POP];
  logic [GENOME_W-1:0] nxt_mem [MAX_POP];
  logic [SCORE_W-1:0]  fit_mem [MAX_POP];
  logic [MAX_POP-1:0]  fit_valid;

  in_word_t            item;
  logic [POP_W-1:0]    k;
  logic [POP_W-1:0]    last;
  logic [GENOME_W-1:0] cur_q;
  logic [GENOME_W-1:0] nxt_q;
  logic [GENOME_W-1:0] ga;
  logic [SCORE_W-1:0]  fit_q;
  logic                fit_v_q;
  logic [POP_W-1:0]    cur_addr;
  logic [SUM_W-1:0]    sum;
  logic [SUM_W-1:0]    run;
  logic [SUM_W-1:0]    run_next;
  logic [SUM_W-1:0]    pt1;
  logic [SUM_W-1:0]    pt2;
  logic [CUT_W-1:0]    cut;
  logic [DRAW_W-3:0]   cut_quarter;
  logic [2*DRAW_W-3:0] cut_prod;
  logic [SUM_W-1:0]    cut_quot;
  logic [DRAW_W-1:0]   cut_rem;
  logic                found;
  logic [POP_W-1:0]    pidx;
  logic [POP_W-1:0]    pa;
  logic [POP_W-1:0]    pb;
  logic                a_done;
  logic                b_done;
  logic                a_hit;
  logic                b_hit;
  logic [GENES-1:0]    eq;
  logic [SCORE_W-1:0]  score;
  logic [GENOME_W-1:0] child;
  logic [SCORE_W-1:0]  fit_cur;
  logic                div_done;
  logic [SUM_W-1:0]    div_rem;
  logic [DRAW_W-1:0]   div_n;
  logic [SUM_W-1:0]    div_d;

  // Last organism in use: zero counts as one, anything above the store as full.
  always_comb begin
    if (population_size == '0) begin
      last = '0;
    end else if (population_size > SIZE_W'(MAX_POP)) begin
      last = POP_W'(MAX_POP - 1);
    end else begin
      last = POP_W'(population_size - SIZE_W'(1));
    end
  end

  // Gene match count against the model.
  always_comb begin
    for (int i = 0; i < GENES; i++) begin
      eq[i] = (cur_q[i*ALLELE_W +: ALLELE_W] == model_genome[i*ALLELE_W +: ALLELE_W]);
    end
    score = SCORE_W'($countones(eq));
  end

  // Crossover point: the draw modulo twenty. The quotient is the draw over four times
  // the reciprocal of five, which is exact for every sixteen-bit draw.
  always_comb begin
    cut_quarter = item.crossover_draw[DRAW_W-1:2];
    cut_prod    = {{DRAW_W{1'b0}}, cut_quarter} * (2*DRAW_W-2)'(52429);
    cut_quot    = cut_prod[2*DRAW_W-3:18];
    cut_rem     = item.crossover_draw - ({4'd0, cut_quot} * DRAW_W'(GENES));
    cut         = cut_rem[CUT_W-1:0];
  end

  // Crossover below the cut, mutation over both parents.
  always_comb begin
    for (int i = 0; i < GENES; i++) begin
      if (item.mutation_mask[i]) begin
        child[i*ALLELE_W +: ALLELE_W] = item.mutant_genome[i*ALLELE_W +: ALLELE_W];
      end else if (CUT_W'(i) < cut) begin
        child[i*ALLELE_W +: ALLELE_W] = ga[i*ALLELE_W +: ALLELE_W];
      end else begin
        child[i*ALLELE_W +: ALLELE_W] = cur_q[i*ALLELE_W +: ALLELE_W];
      end
    end
  end

  // Roulette wheel walk over the stored scores.
  assign fit_cur  = fit_v_q ? fit_q : '0;
  assign run_next = run + SUM_W'(fit_cur);
  assign a_hit    = a_done || (run_next >= pt1);
  assign b_hit    = b_done || (run_next >= pt2);

  // Shared remainder unit for the two parent draws.
  always_comb begin
    unique case (cmd.div_sel)
      DIV_P2: begin
        div_n = item.select_draw_two;
        div_d = sum + SUM_W'(1);
      end
      default: begin
        div_n = item.select_draw_one;
        div_d = sum + SUM_W'(1);
      end
    endcase
  end

  gae_div u_div (
    .clk       (clk),
    .rst       (rst),
    .start     (cmd.div_go),
    .dividend  (div_n),
    .divisor   (div_d),
    .done      (div_done),
    .remainder (div_rem)
  );

  assign cur_addr = cmd.rd_a ? pa : (cmd.rd_b ? pb : k);

  // Population memories with registered reads.
  always_ff @(posedge clk) begin
    if (cmd.load_wr) begin
      cur_mem[item.organism_index] <= item.genome;
    end else if (cmd.cm_wr) begin
      cur_mem[k] <= nxt_q;
    end
    cur_q <= cur_mem[cur_addr];
  end

  always_ff @(posedge clk) begin
    if (cmd.child_wr) begin
      nxt_mem[item.organism_index] <= child;
    end
    nxt_q <= nxt_mem[k];
  end

  // Score store; entries never written read as zero.
  always_ff @(posedge clk) begin
    if (cmd.ev_sc) begin
      fit_mem[k] <= score;
    end
    fit_q <= fit_mem[k];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      fit_valid <= '0;
      fit_v_q   <= 1'b0;
      sum       <= '0;
    end else begin
      fit_v_q <= fit_valid[k];
      if (cmd.ev_sc) begin
        fit_valid[k] <= 1'b1;
        sum          <= sum + SUM_W'(score);
      end else if (cmd.latch && (in_word.action == ACT_EVAL)) begin
        sum <= '0;
      end
    end
  end

  // Item, index and result registers.
  always_ff @(posedge clk) begin
    if (cmd.latch) begin
      item   <= in_word;
      k      <= '0;
      run    <= '0;
      found  <= 1'b0;
      pidx   <= '0;
      pa     <= '0;
      pb     <= '0;
      a_done <= 1'b0;
      b_done <= 1'b0;
    end else begin
      if (cmd.ev_sc) begin
        if (score == SCORE_W'(GENES)) begin
          found <= 1'b1;
          pidx  <= k;
        end else if (k != last) begin
          k <= k + POP_W'(1);
        end
      end
      if (cmd.div_take && div_done) begin
        unique case (cmd.div_sel)
          DIV_P2:  pt2 <= div_rem;
          default: pt1 <= div_rem;
        endcase
      end
      if (cmd.wk_chk) begin
        run    <= run_next;
        a_done <= a_hit;
        b_done <= b_hit;
        if (!a_done) begin
          pa <= k;
        end
        if (!b_done) begin
          pb <= k;
        end
        if (!(a_hit && b_hit) && (k != last)) begin
          k <= k + POP_W'(1);
        end
      end
      if (cmd.rd_b) begin
        ga <= cur_q;
      end
      if (cmd.cm_wr && (k != last)) begin
        k <= k + POP_W'(1);
      end
    end
  end

  assign stat.ev_stop  = (score == SCORE_W'(GENES)) || (k == last);
  assign stat.div_done = div_done;
  assign stat.wk_stop  = (a_hit && b_hit) || (k == last);
  assign stat.k_last   = (k == last);

  assign result.perfect_found = found;
  assign result.perfect_index = pidx;
  assign result.fitness_total = sum;
  assign result.parent_one    = pa;
  assign result.parent_two    = pb;

endmodule

// ===== rtl/genetic_algorithm_generation_engine_top.sv =====
// Per word: load writes one genome, evaluate scores the organisms until a perfect one or the
// last in use, commit copies those in use, and breed walks until both parents are found.
// Throughput is one word at a time; the walks over the score and population memories and
// the remainder unit (used twice per breed) set it.
// Reset (rst, synchronous) empties the output register, zeroes the score store and
// total, and restores model_genome to zero and population_size to 100.
module genetic_algorithm_generation_engine_top
  import gae_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_stall,
  input  in_word_t          in_word,
  output logic              out_valid,
  input  logic              out_stall,
  output out_word_t         out_word,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [APB_AW-1:0] paddr,
  input  logic [APB_DW-1:0] pwdata,
  output logic [APB_DW-1:0] prdata,
  output logic              pready
);

  logic [GENOME_W-1:0] model_genome;
  logic [SIZE_W-1:0]   population_size;
  gae_cmd_t            cmd;
  gae_stat_t           stat;
  out_word_t           result;
  logic                out_free;
  logic                out_load;

  // Configuration registers.
  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      model_genome    <= '0;
      population_size <= SIZE_W'(100);
    end else if (psel && penable && pwrite) begin
      unique case (paddr)
        ADDR_MODEL: model_genome    <= pwdata[GENOME_W-1:0];
        ADDR_SIZE:  population_size <= pwdata[SIZE_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr)
      ADDR_MODEL: prdata = {{(APB_DW-GENOME_W){1'b0}}, model_genome};
      ADDR_SIZE:  prdata = {{(APB_DW-SIZE_W){1'b0}}, population_size};
      default:    prdata = '0;
    endcase
  end

  // Output register parts the result from the next word's work.
  assign out_free = !out_valid || !out_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_word <= result;
    end
  end

  gae_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .action   (action_t'(in_word.action)),
    .out_free (out_free),
    .stat     (stat),
    .in_stall (in_stall),
    .out_load (out_load),
    .cmd      (cmd)
  );

  gae_dp u_dp (
    .clk             (clk),
    .rst             (rst),
    .cmd             (cmd),
    .in_word         (in_word),
    .model_genome    (model_genome),
    .population_size (population_size),
    .stat            (stat),
    .result          (result)
  );

endmodule

// ===== rtl/gae_checker.sv =====
module gae_checker
  import gae_pkg::*;
(
  input logic      clk,
  input logic      rst,
  input logic      in_valid,
  input logic      in_stall,
  input logic      out_valid,
  input logic      out_stall,
  input out_word_t out_word
);

  // The engine takes one word at a time.
  a_one_at_a_time: assert property (@(posedge clk) disable iff (rst)
    (in_valid && !in_stall) |=> in_stall)
    else $error("second word accepted while one is in work");

  // A stalled result is kept.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_stall) |=> (out_valid && $stable(out_word)))
    else $error("stalled result dropped or changed");

  // An evaluation result that reports a perfect organism carries no parents.
  a_eval_no_parents: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_word.perfect_found) |->
      (out_word.parent_one == '0 && out_word.parent_two == '0))
    else $error("parents reported on an evaluation");

  // The total never exceeds a full population of perfect scores.
  a_total_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (out_word.fitness_total <= SUM_W'(MAX_POP * GENES)))
    else $error("fitness total out of range");

endmodule

bind genetic_algorithm_generation_engine_top gae_checker u_gae_checker (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (in_valid),
  .in_stall  (in_stall),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_word  (out_word)
);

// ===== bench/tb_top.sv =====
module tb_top
  import gae_pkg::*;
();

  timeunit 1ns;
  timeprecision 1ps;

  // Bit-accurate predictor of the engine plus the queue of words still owed by it.
  class gae_scoreboard;
    logic [GENOME_W-1:0] model;
    logic [SIZE_W-1:0]   pop_size;
    logic [GENOME_W-1:0] cur_pop[MAX_POP];
    logic [GENOME_W-1:0] nxt_pop[MAX_POP];
    logic [SCORE_W-1:0]  scores[MAX_POP];
    logic [SUM_W-1:0]    score_sum;
    out_word_t           owed[$];
    int                  errors;

    function void clear();
      model = '0;
      pop_size = 8'd100;
      score_sum = '0;
      errors = 0;
      owed.delete();
      for (int k = 0; k < MAX_POP; k++) begin
        cur_pop[k] = '0;
        nxt_pop[k] = '0;
        scores[k] = '0;
      end
    endfunction

    // Zero is treated as one, anything above the store depth as the full depth.
    function int used();
      if (pop_size == 0) return 1;
      if (pop_size > MAX_POP) return MAX_POP;
      return int'(pop_size);
    endfunction

    function int spin_wheel(logic [DRAW_W-1:0] draw);
      int n;
      int point;
      int run;
      n = used();
      point = int'(draw) % (int'(score_sum) + 1);
      run = 0;
      for (int k = 0; k < n; k++) begin
        run += int'(scores[k]);
        if (run >= point) return k;
      end
      return n - 1;
    endfunction

    // Works out the word that an accepted input word will produce.
    function void note_input(in_word_t w);
      out_word_t r;
      int n;
      int a;
      int b;
      int cut;
      int score;
      logic [GENOME_W-1:0] child;
      r = '0;
      n = used();
      case (action_t'(w.action))
        ACT_LOAD: begin
          cur_pop[w.organism_index] = w.genome;
        end
        ACT_EVAL: begin
          score_sum = '0;
          for (int k = 0; k < n; k++) begin
            score = 0;
            for (int i = 0; i < GENES; i++)
              if (cur_pop[k][i*ALLELE_W +: ALLELE_W] == model[i*ALLELE_W +: ALLELE_W])
                score++;
            scores[k] = SCORE_W'(score);
            score_sum = score_sum + SUM_W'(score);
            if (score == GENES) begin
              r.perfect_found = 1'b1;
              r.perfect_index = POP_W'(k);
              break;
            end
          end
        end
        ACT_BREED: begin
          a = spin_wheel(w.select_draw_one);
          b = spin_wheel(w.select_draw_two);
          cut = int'(w.crossover_draw) % GENES;
          for (int i = 0; i < GENES; i++) begin
            if (w.mutation_mask[i])
              child[i*ALLELE_W +: ALLELE_W] = w.mutant_genome[i*ALLELE_W +: ALLELE_W];
            else if (i < cut)
              child[i*ALLELE_W +: ALLELE_W] = cur_pop[a][i*ALLELE_W +: ALLELE_W];
            else
              child[i*ALLELE_W +: ALLELE_W] = cur_pop[b][i*ALLELE_W +: ALLELE_W];
          end
          nxt_pop[w.organism_index] = child;
          r.parent_one = POP_W'(a);
          r.parent_two = POP_W'(b);
        end
        ACT_COMMIT: begin
          for (int k = 0; k < n; k++) cur_pop[k] = nxt_pop[k];
        end
      endcase
      r.fitness_total = score_sum;
      owed.push_back(r);
    endfunction

    function void check_result(out_word_t got);
      out_word_t exp;
      if (owed.size() == 0) begin
        $error("result word with nothing expected: %h", got);
        errors++;
        return;
      end
      exp = owed.pop_front();
      if (got.perfect_found !== exp.perfect_found) begin
        $error("perfect_found: expected %0d, got %0d", exp.perfect_found, got.perfect_found);
        errors++;
      end
      if (got.perfect_index !== exp.perfect_index) begin
        $error("perfect_index: expected %0d, got %0d", exp.perfect_index, got.perfect_index);
        errors++;
      end
      if (got.fitness_total !== exp.fitness_total) begin
        $error("fitness_total: expected %0d, got %0d", exp.fitness_total, got.fitness_total);
        errors++;
      end
      if (got.parent_one !== exp.parent_one) begin
        $error("parent_one: expected %0d, got %0d", exp.parent_one, got.parent_one);
        errors++;
      end
      if (got.parent_two !== exp.parent_two) begin
        $error("parent_two: expected %0d, got %0d", exp.parent_two, got.parent_two);
        errors++;
      end
    endfunction
  endclass

  logic              clk;
  logic              rst;
  logic              in_valid;
  logic              in_stall;
  in_word_t          in_word;
  logic              out_valid;
  logic              out_stall;
  out_word_t         out_word;
  logic              psel;
  logic              penable;
  logic              pwrite;
  logic [APB_AW-1:0] paddr;
  logic [APB_DW-1:0] pwdata;
  logic [APB_DW-1:0] prdata;
  logic              pready;

  gae_scoreboard sb;
  int  send_idle_pct;
  int  recv_stall_pct;
  int  hold_off;
  bit  cur_loaded[MAX_POP];
  bit  nxt_bred[MAX_POP];

  genetic_algorithm_generation_engine_top DUT (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall), .in_word(in_word),
    .out_valid(out_valid), .out_stall(out_stall), .out_word(out_word),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  always begin
    clk = 1'b1;
    #2;
    clk = 1'b0;
    #2;
  end

  // Watchdog for a hung run.
  initial begin
    #25ms;
    $display("tb_top: done, errors");
    $finish;
  end

  // Accepted words on both sides go to the scoreboard.
  always @(posedge clk) begin
    if (!rst && in_valid && !in_stall) sb.note_input(in_word);
    if (!rst && out_valid && !out_stall) sb.check_result(out_word);
  end

  // Receiver: random stalls, or a long hold-off when one is pending.
  always @(negedge clk) begin
    if (hold_off > 0) begin
      out_stall <= 1'b1;
      hold_off <= hold_off - 1;
    end else begin
      out_stall <= ($urandom_range(99) < recv_stall_pct);
    end
  end

  task automatic send_word(in_word_t w);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid = 1'b0;
      @(negedge clk);
    end
    in_valid = 1'b1;
    in_word = w;
    do @(posedge clk); while (in_stall);
    @(negedge clk);
  endtask

  task automatic reg_write(logic [APB_AW-1:0] addr, logic [APB_DW-1:0] data);
    psel = 1'b1;
    penable = 1'b0;
    pwrite = 1'b1;
    paddr = addr;
    pwdata = data;
    @(negedge clk);
    penable = 1'b1;
    @(negedge clk);
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    if (addr == ADDR_MODEL) sb.model = data[GENOME_W-1:0];
    else sb.pop_size = data[SIZE_W-1:0];
  endtask

  // Registers change only once the engine has drained.
  task automatic settle_and_configure(logic [GENOME_W-1:0] model, logic [SIZE_W-1:0] size);
    in_valid = 1'b0;
    @(negedge clk);
    while (sb.owed.size() != 0) @(negedge clk);
    repeat (400) @(negedge clk);
    reg_write(ADDR_MODEL, APB_DW'(model));
    reg_write(ADDR_SIZE, APB_DW'(size));
  endtask

  function automatic in_word_t make_word(action_t act, int idx);
    in_word_t w;
    w.action = act;
    w.organism_index = POP_W'(idx);
    w.genome = GENOME_W'({$urandom, $urandom});
    w.select_draw_one = DRAW_W'($urandom);
    w.select_draw_two = DRAW_W'($urandom);
    w.crossover_draw = DRAW_W'($urandom);
    w.mutation_mask = GENES'($urandom);
    w.mutant_genome = GENOME_W'({$urandom, $urandom});
    return w;
  endfunction

  function automatic int first_gap(bit flags[MAX_POP], int n);
    for (int k = 0; k < n; k++)
      if (!flags[k]) return k;
    return -1;
  endfunction

  // Random word; actions that would read unwritten genomes become loads or breeds.
  function automatic in_word_t random_word();
    in_word_t w;
    int n;
    int pick;
    int gap;
    action_t act;
    n = sb.used();
    pick = $urandom_range(99);
    act = (pick < 25) ? ACT_LOAD : (pick < 50) ? ACT_EVAL : (pick < 88) ? ACT_BREED : ACT_COMMIT;
    w = make_word(act, $urandom_range(MAX_POP - 1));
    if ($urandom_range(3) == 0) w.organism_index = POP_W'($urandom_range(n - 1));
    case ($urandom_range(3))
      0: w.genome = sb.model;
      1: w.genome = sb.model ^ (40'h3 << (2 * $urandom_range(GENES - 1)));
      default: ;
    endcase
    case ($urandom_range(3))
      0: w.mutation_mask = '0;
      1: w.mutation_mask = 20'h1 << $urandom_range(GENES - 1);
      default: ;
    endcase
    if ($urandom_range(1)) begin
      w.select_draw_one = DRAW_W'($urandom_range(sb.score_sum));
      w.select_draw_two = DRAW_W'($urandom_range(sb.score_sum));
    end
    if (w.action == ACT_COMMIT) begin
      gap = first_gap(nxt_bred, n);
      if (gap >= 0) begin
        w.action = ACT_BREED;
        w.organism_index = POP_W'(gap);
      end
    end
    if (w.action == ACT_EVAL || w.action == ACT_BREED) begin
      gap = first_gap(cur_loaded, n);
      if (gap >= 0) begin
        w.action = ACT_LOAD;
        w.organism_index = POP_W'(gap);
      end
    end
    return w;
  endfunction

  task automatic send_tracked(in_word_t w);
    if (w.action == ACT_LOAD) cur_loaded[w.organism_index] = 1'b1;
    if (w.action == ACT_BREED) nxt_bred[w.organism_index] = 1'b1;
    send_word(w);
  endtask

  initial begin
    in_word_t w;
    logic [GENOME_W-1:0] models[8];
    logic [SIZE_W-1:0]   sizes[8];
    sb = new();
    sb.clear();
    rst = 1'b1;
    in_valid = 1'b0;
    in_word = '0;
    out_stall = 1'b0;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    send_idle_pct = 0;
    recv_stall_pct = 0;
    hold_off = 0;
    repeat (10) @(negedge clk);
    rst = 1'b0;
    @(negedge clk);

    // Directed part on a population of four.
    reg_write(ADDR_SIZE, 64'd4);
    w = make_word(ACT_LOAD, 0); w.genome = '0;  send_tracked(w);
    w = make_word(ACT_LOAD, 1); w.genome = '1;  send_tracked(w);
    w = make_word(ACT_LOAD, 2); w.genome = 40'h5555555555; send_tracked(w);
    w = make_word(ACT_LOAD, 3); w.genome = 40'hAAAAAAAAAA; send_tracked(w);
    // Model of zero makes organism 0 perfect, so evaluation stops early.
    w = make_word(ACT_EVAL, 0); send_tracked(w);
    w = make_word(ACT_LOAD, 0); w.genome = 40'h0000000003; send_tracked(w);
    w = make_word(ACT_EVAL, 0); send_tracked(w);
    w = make_word(ACT_BREED, 0);
    w.select_draw_one = '0; w.select_draw_two = '1; w.crossover_draw = '0;
    w.mutation_mask = '0; send_tracked(w);
    w = make_word(ACT_BREED, 1);
    w.select_draw_one = '1; w.select_draw_two = '0; w.crossover_draw = '1;
    w.mutation_mask = '1; w.mutant_genome = '1; send_tracked(w);
    w = make_word(ACT_BREED, 2); w.crossover_draw = 16'd19; w.mutation_mask = '0; send_tracked(w);
    w = make_word(ACT_BREED, 3); w.crossover_draw = 16'd20; send_tracked(w);
    w = make_word(ACT_BREED, 127); w.mutation_mask = 20'h80000; send_tracked(w);
    w = make_word(ACT_COMMIT, 0); send_tracked(w);
    w = make_word(ACT_EVAL, 0); send_tracked(w);
    w = make_word(ACT_LOAD, 127); w.genome = '1; send_tracked(w);
    w = make_word(ACT_LOAD, 2); w.genome = '0; send_tracked(w);
    w = make_word(ACT_EVAL, 0); send_tracked(w);
    w = make_word(ACT_BREED, 1); w.select_draw_one = 16'd1; w.select_draw_two = 16'd2;
    send_tracked(w);

    // Random phases over a spread of settings, extremes included.
    models = '{40'hFFFFFFFFFF, 40'h0, 40'h1B1B1B1B1B, 40'hFFFFFFFFFF,
               40'h123456789A, 40'hAAAAAAAAAA, 40'h0, 40'h5555555555};
    sizes  = '{8'd1, 8'd128, 8'd0, 8'd255, 8'd2, 8'd37, 8'd100, 8'd127};
    for (int ph = 0; ph < 8; ph++) begin
      settle_and_configure((ph == 2) ? GENOME_W'({$urandom, $urandom}) : models[ph],
                           sizes[ph]);
      case (ph % 4)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 81; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 81; end
        default: begin send_idle_pct = 30; recv_stall_pct = 30; end
      endcase
      // One long hold-off on the output while words keep coming.
      if (ph == 4) hold_off = 3000;
      for (int it = 0; it < 166; it++) send_tracked(random_word());
    end

    in_valid = 1'b0;
    while (sb.owed.size() != 0) @(negedge clk);
    repeat (400) @(negedge clk);
    if (sb.errors == 0 && sb.owed.size() == 0) begin
      $display("tb_top: done, clean");
    end else begin
      $display("tb_top: done, errors");
    end
    $finish;
  end

endmodule
